// File: rtl/sasrl_pkg.sv
// shared types, constants and helpers for the steering angle smoothing rate limiter
`timescale 1ns / 1ps

package sasrl_pkg;

    // field widths
    localparam int ANGLE_W   = 16;
    localparam int RATE_W    = 20;
    localparam int RATE_HI_W = 19;
    localparam int TAU_W     = 24;
    localparam int STEP_W    = 20;
    localparam int CFG_IDX_W = 3;

    // shared multiplier and divider widths
    localparam int OP_W   = 21;              // signed operand before magnitude
    localparam int MUL_W  = 20;              // unsigned multiplier inputs
    localparam int PROD_W = 2 * MUL_W;       // product
    localparam int NUM_W  = PROD_W + 1;      // dividend with rounding half added
    localparam int DEN_W  = 25;              // divisor
    localparam int WIDE_W = NUM_W + 1;       // signed quotient
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [MUL_W-1:0] US_PER_S = MUL_W'(1000000);

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [RATE_W-1:0]  t_rate;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    localparam t_wide RATE_OUT_MAX = t_wide'(524287);
    localparam t_wide RATE_OUT_MIN = -t_wide'(524288);
    localparam logic [NUM_W-1:0] ANGLE_SPAN = NUM_W'(65535);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_POST,
        S_DONE
    } t_state;

    // which of the four divisions is running
    typedef enum logic [1:0] {
        PH_SMOOTH,
        PH_DRIVE,
        PH_STEP,
        PH_RATE
    } t_phase;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_LOW    = 3'd0,
        REG_ANGLE_HIGH   = 3'd1,
        REG_RATE_LOW     = 3'd2,
        REG_RATE_HIGH    = 3'd3,
        REG_ACT_TAU      = 3'd4,
        REG_SMOOTH_TAU   = 3'd5
    } t_cfg_reg;

    // upper bound first, then lower bound, so inverted limits give lo
    function automatic t_wide clamp_wide(input t_wide v, input t_wide lo, input t_wide hi);
        t_wide r;
        r = v;
        if (r > hi) r = hi;
        if (r < lo) r = lo;
        return r;
    endfunction

endpackage

// File: rtl/steer_angle_smoothing_rate_limiter_top.sv
// steering angle smoothing and rate limiter around one shared multiplier and divider
//
// Input stream (s_axis_*): one beat per control step. tuser is the mode bit
// (0 update, 1 reset target to measured angle); tdata packs the command angle,
// measured_angle and step_us, Q4.12 radians and microseconds.
// Output stream (m_axis_*): one beat per input beat with smoothed_target,
// next_angle and the saturated angle_rate.
// Config channel (i_cfg_*): register index and data, always ready; writes must
// be made only while no beat is in flight, which the block does not enforce.
// Flow: an update beat runs up to four divisions on one restoring divider,
// each with its own multiply, add and post step; four divisions with
// smoothing and three without. The result is then loaded into the output
// register once that is free, which raises m_axis_tvalid, and only then is
// a new beat taken. A reset beat goes straight to the done state and its
// result into the output register. s_axis_tready is high only between beats.
// Reset clears the sequencer, the output valid and the kept target and
// loads the register defaults. A stalled receiver holds the output
// register; the next input beat is still taken and worked on, and its
// result waits in the sequencer until the output register frees up.
`timescale 1ns / 1ps

module steer_angle_smoothing_rate_limiter_top
    import sasrl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,   // command angle, measured_angle, step_us, pad
    input  logic                 s_axis_tuser,   // mode
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // smoothed_target, next_angle, angle_rate, pad
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TAU_W-1:0]     i_cfg_data
);

    // configuration registers
    t_angle                 r_angle_lo;
    t_angle                 r_angle_hi;
    t_rate                  r_rate_lo;
    logic [RATE_HI_W-1:0]   r_rate_hi;
    logic [TAU_W-1:0]       r_act_tau;
    logic [TAU_W-1:0]       r_smooth_tau;

    // sequencer and working values
    t_state                 r_state, n_state;
    t_phase                 r_phase;
    t_angle                 r_target;
    t_angle                 r_meas;
    t_angle                 r_des;
    logic [STEP_W-1:0]      r_step;
    t_rate                  r_rate;
    t_angle                 r_next;
    t_rate                  r_res_rate;

    // shared arithmetic unit
    logic [PROD_W-1:0]      r_prod;
    logic [DEN_W-1:0]       r_den;
    logic                   r_neg;
    logic [NUM_W-1:0]       r_quo;
    logic [DEN_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_count;

    // output register
    logic                   r_out_valid;
    t_angle                 r_out_target;
    t_angle                 r_out_next;
    t_rate                  r_out_rate;

    logic                   w_accept;
    logic                   w_load_out;
    logic                   w_div_last;
    t_angle                 w_in_des;
    t_angle                 w_in_meas;
    logic [STEP_W-1:0]      w_in_step;
    t_angle                 w_des_c;
    t_angle                 w_meas_c;
    t_wide                  w_lo;
    t_wide                  w_hi;
    logic signed [OP_W-1:0] w_op;
    logic [OP_W-1:0]        w_op_abs;
    logic [MUL_W-1:0]       w_mul_b;
    logic [DEN_W-1:0]       w_den;
    logic [DEN_W:0]         w_shift;
    logic [DEN_W+1:0]       w_trial;
    t_wide                  w_qmag;
    t_wide                  w_sq;

    // input field unpacking and angle clamps
    assign w_in_des  = t_angle'(s_axis_tdata[15:0]);
    assign w_in_meas = t_angle'(s_axis_tdata[31:16]);
    assign w_in_step = s_axis_tdata[51:32];
    assign w_lo      = t_wide'(r_angle_lo);
    assign w_hi      = t_wide'(r_angle_hi);
    assign w_des_c   = t_angle'(clamp_wide(t_wide'(w_in_des), w_lo, w_hi));
    assign w_meas_c  = t_angle'(clamp_wide(t_wide'(w_in_meas), w_lo, w_hi));

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_accept      = s_axis_tvalid && (r_state == S_IDLE);
        w_load_out    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        w_div_last    = (r_count == CNT_W'(NUM_W - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = s_axis_tuser ? S_DONE : S_MUL;
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_DIV;
            S_DIV: begin
                if (w_div_last) n_state = S_POST;
            end
            S_POST: n_state = (r_phase == PH_RATE) ? S_DONE : S_MUL;
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // operand selection for the shared multiplier and divisor
    always_comb begin
        unique case (r_phase)
            PH_SMOOTH: begin
                w_op    = OP_W'(r_des) - OP_W'(r_target);
                w_mul_b = r_step;
                w_den   = DEN_W'(r_smooth_tau) + DEN_W'(r_step);
            end
            PH_DRIVE: begin
                w_op    = OP_W'(r_target) - OP_W'(r_meas);
                w_mul_b = US_PER_S;
                w_den   = (r_act_tau == '0) ? DEN_W'(1) : DEN_W'(r_act_tau);
            end
            PH_STEP: begin
                w_op    = OP_W'(r_rate);
                w_mul_b = r_step;
                w_den   = DEN_W'(US_PER_S);
            end
            PH_RATE: begin
                w_op    = OP_W'(r_next) - OP_W'(r_meas);
                w_mul_b = US_PER_S;
                w_den   = DEN_W'(r_step);
            end
            default: begin
                w_op    = '0;
                w_mul_b = '0;
                w_den   = DEN_W'(1);
            end
        endcase
        w_op_abs = w_op[OP_W-1] ? OP_W'(-w_op) : OP_W'(w_op);
    end

    // one restoring step and the signed quotient
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_trial = {1'b0, w_shift} - {2'b00, r_den};
        w_qmag  = t_wide'({1'b0, r_quo});
        w_sq    = r_neg ? -w_qmag : w_qmag;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_lo   <= t_angle'(-2048);
            r_angle_hi   <= t_angle'(2048);
            r_rate_lo    <= t_rate'(-4096);
            r_rate_hi    <= RATE_HI_W'(4096);
            r_act_tau    <= TAU_W'(100000);
            r_smooth_tau <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ANGLE_LOW:  r_angle_lo   <= t_angle'(i_cfg_data[ANGLE_W-1:0]);
                REG_ANGLE_HIGH: r_angle_hi   <= t_angle'(i_cfg_data[ANGLE_W-1:0]);
                REG_RATE_LOW:   r_rate_lo    <= t_rate'(i_cfg_data[RATE_W-1:0]);
                REG_RATE_HIGH:  r_rate_hi    <= i_cfg_data[RATE_HI_W-1:0];
                REG_ACT_TAU:    r_act_tau    <= i_cfg_data;
                REG_SMOOTH_TAU: r_smooth_tau <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer state and kept target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_SMOOTH;
            r_target <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (s_axis_tuser) begin
                    r_target <= w_meas_c;
                end else if (r_smooth_tau == '0) begin
                    r_target <= w_des_c;
                    r_phase  <= PH_DRIVE;
                end else begin
                    r_phase  <= PH_SMOOTH;
                end
            end else if (r_state == S_POST) begin
                if (r_phase == PH_SMOOTH) begin
                    r_target <= t_angle'(clamp_wide(t_wide'(r_target) + w_sq, w_lo, w_hi));
                end
                r_phase <= t_phase'(r_phase + 2'd1);
            end
        end
    end

    // working values and shared multiply / divide datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_des  <= w_des_c;
            r_meas <= w_meas_c;
            r_step <= (w_in_step == '0) ? STEP_W'(1) : w_in_step;
            if (s_axis_tuser) begin
                r_next     <= w_meas_c;
                r_res_rate <= '0;
            end
        end
        unique case (r_state)
            S_MUL: begin
                r_prod <= w_op_abs[MUL_W-1:0] * w_mul_b;
                r_den  <= w_den;
                r_neg  <= w_op[OP_W-1];
            end
            S_ADD: begin
                r_quo   <= {1'b0, r_prod} + NUM_W'(r_den >> 1);
                r_rem   <= '0;
                r_count <= '0;
            end
            S_DIV: begin
                if (!w_trial[DEN_W+1]) begin
                    r_rem <= w_trial[DEN_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DEN_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
                r_count <= r_count + CNT_W'(1);
            end
            S_POST: begin
                unique case (r_phase)
                    PH_DRIVE: r_rate <= t_rate'(clamp_wide(w_sq, t_wide'(r_rate_lo),
                                                           t_wide'({1'b0, r_rate_hi})));
                    PH_STEP:  r_next <= t_angle'(clamp_wide(t_wide'(r_meas) + w_sq,
                                                            w_lo, w_hi));
                    PH_RATE:  r_res_rate <= t_rate'(clamp_wide(w_sq, RATE_OUT_MIN,
                                                               RATE_OUT_MAX));
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_target <= r_target;
            r_out_next   <= r_next;
            r_out_rate   <= r_res_rate;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_rate, r_out_next, r_out_target};

    // a taken beat keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    // the divider never runs past its last step
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count < CNT_W'(NUM_W)))
        else $error("divider step count overran");

    // smoothing correction never exceeds the angle difference span
    a_smooth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && r_phase == PH_SMOOTH) |-> (r_quo <= ANGLE_SPAN))
        else $error("smoothing quotient out of range");

    // the applied angle step fits the step field
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && r_phase == PH_STEP) |-> (r_quo[NUM_W-1:STEP_W] == '0))
        else $error("angle step quotient out of range");

endmodule

// File: dv/tb_steer_angle_smoothing_rate_limiter_top.sv
// self-checking testbench for the steering angle smoothing rate limiter top level
`timescale 1ns / 1ps

module tb_steer_angle_smoothing_rate_limiter_top
    import sasrl_pkg::*;
();

    localparam int     CYCLE_LIMIT   = 1_500_000;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_ITEMS   = 112;
    localparam longint US_PER_SEC    = 1000000;
    localparam longint RATE_CEIL     = 524287;
    localparam longint RATE_FLOOR    = -524288;
    localparam logic   MODE_UPDATE   = 1'b0;
    localparam logic   MODE_RESET    = 1'b1;

    // one control step as sent, plus its pacing
    typedef struct {
        logic              mode;
        t_angle            desired;
        t_angle            measured;
        logic [STEP_W-1:0] step_us;
        int                gap;
        bit                after_ready;
        bit                drain_first;
    } t_steer_cmd;

    // one result beat
    typedef struct {
        t_angle smoothed;
        t_angle next_ang;
        t_rate  rate;
    } t_steer_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata = '0;   // command angle, measured_angle, step_us, pad
    logic                 s_axis_tuser = 1'b0; // mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [55:0]          m_axis_tdata;        // smoothed_target, next_angle, angle_rate, pad
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TAU_W-1:0]     i_cfg_data = '0;

    // limiter model state, register defaults after reset
    longint m_angle_lo   = -2048;
    longint m_angle_hi   = 2048;
    longint m_rate_lo    = -4096;
    longint m_rate_hi    = 4096;
    longint m_act_tau    = 100000;
    longint m_smooth_tau = 0;
    longint m_target     = 0;

    t_steer_cmd cmd_backlog[$];
    t_steer_out expected_outputs[$];
    t_steer_cmd cmd_live;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_resets    = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_writes    = 0;
    int n_settings  = 0;
    int rx_wait     = 0;
    int rx_calm_pct = 100;
    int cycle_count = 0;

    steer_angle_smoothing_rate_limiter_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // division rounded to nearest, ties away from zero, den > 0
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    // upper bound first, so inverted limits settle on the lower one
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic longint rand_between(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    // smoothing filter and rate limiter for one step, updates the kept target
    function automatic t_steer_out limit_step(input t_steer_cmd c);
        t_steer_out o;
        longint dt;
        longint meas_c;
        longint des_c;
        longint tau;
        longint rate;
        longint next_ang;
        dt = (c.step_us == 0) ? 1 : longint'(c.step_us);
        meas_c = clip(longint'(c.measured), m_angle_lo, m_angle_hi);
        if (c.mode == MODE_RESET) begin
            m_target = meas_c;
            next_ang = meas_c;
            rate = 0;
        end else begin
            des_c = clip(longint'(c.desired), m_angle_lo, m_angle_hi);
            tau = (m_act_tau == 0) ? 1 : m_act_tau;
            if (m_smooth_tau > 0) begin
                m_target += round_div((des_c - m_target) * dt, m_smooth_tau + dt);
            end else begin
                m_target = des_c;
            end
            m_target = clip(m_target, m_angle_lo, m_angle_hi);
            rate = round_div((m_target - meas_c) * US_PER_SEC, tau);
            rate = clip(rate, m_rate_lo, m_rate_hi);
            next_ang = meas_c + round_div(rate * dt, US_PER_SEC);
            next_ang = clip(next_ang, m_angle_lo, m_angle_hi);
            // rate actually achieved over the step
            rate = round_div((next_ang - meas_c) * US_PER_SEC, dt);
            rate = clip(rate, RATE_FLOOR, RATE_CEIL);
        end
        o.smoothed = t_angle'(m_target);
        o.next_ang = t_angle'(next_ang);
        o.rate     = t_rate'(rate);
        return o;
    endfunction

    task automatic queue_cmd(input logic mode, input longint des, input longint meas,
                             input longint step, input int gap, input bit after_ready,
                             input bit drain_first);
        t_steer_cmd c;
        c.mode        = mode;
        c.desired     = t_angle'(des);
        c.measured    = t_angle'(meas);
        c.step_us     = step[STEP_W-1:0];
        c.gap         = gap;
        c.after_ready = after_ready;
        c.drain_first = drain_first;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    // one register write beat, model updated on the handshake
    task automatic write_reg(input t_cfg_reg idx, input longint val);
        logic [TAU_W-1:0] d;
        case (idx)
            REG_ANGLE_LOW, REG_ANGLE_HIGH: d = {8'd0, val[15:0]};
            REG_RATE_LOW:                  d = {4'd0, val[19:0]};
            REG_RATE_HIGH:                 d = {5'd0, val[18:0]};
            default:                       d = val[23:0];
        endcase
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_ANGLE_LOW:  m_angle_lo   = longint'($signed(d[15:0]));
            REG_ANGLE_HIGH: m_angle_hi   = longint'($signed(d[15:0]));
            REG_RATE_LOW:   m_rate_lo    = longint'($signed(d[19:0]));
            REG_RATE_HIGH:  m_rate_hi    = longint'(d[18:0]);
            REG_ACT_TAU:    m_act_tau    = longint'(d);
            REG_SMOOTH_TAU: m_smooth_tau = longint'(d);
            default: ;
        endcase
        n_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_limits(input longint alo, input longint ahi, input longint rlo,
                                  input longint rhi, input longint atau, input longint stau);
        write_reg(REG_ANGLE_LOW, alo);
        write_reg(REG_ANGLE_HIGH, ahi);
        write_reg(REG_RATE_LOW, rlo);
        write_reg(REG_RATE_HIGH, rhi);
        write_reg(REG_ACT_TAU, atau);
        write_reg(REG_SMOOTH_TAU, stau);
        n_settings++;
    endtask

    // every queued step taken and every result back
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_outputs.size() != 0) @(posedge i_clk);
    endtask

    // input side: predict on each accepted beat, present the next after its gap
    always @(posedge i_clk) begin : tx_side
        bit launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outputs.push_back(limit_step(cmd_live));
                n_accepted++;
                if (cmd_live.mode == MODE_RESET) n_resets++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_backlog.size() > 0) begin
                    if (cmd_backlog[0].gap > 0) begin
                        if (!cmd_backlog[0].after_ready || s_axis_tready) begin
                            cmd_backlog[0].gap = cmd_backlog[0].gap - 1;
                        end
                    end else if (!cmd_backlog[0].drain_first ||
                                 expected_outputs.size() == 0) begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    cmd_live = cmd_backlog.pop_front();
                    s_axis_tdata  <= {4'd0, cmd_live.step_us, cmd_live.measured, cmd_live.desired};
                    s_axis_tuser  <= cmd_live.mode;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each result beat with the oldest prediction, random stalls
    always @(posedge i_clk) begin : rx_side
        t_steer_out want;
        t_steer_out got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.smoothed = m_axis_tdata[15:0];
                got.next_ang = m_axis_tdata[31:16];
                got.rate     = m_axis_tdata[51:32];
                if (expected_outputs.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("unexpected result beat: target %0d next %0d rate %0d",
                                 got.smoothed, got.next_ang, got.rate);
                    end
                end else begin
                    want = expected_outputs.pop_front();
                    n_checked++;
                    if (got.smoothed !== want.smoothed || got.next_ang !== want.next_ang ||
                        got.rate !== want.rate) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display(
                                "result %0d exp/got: target %0d/%0d next %0d/%0d rate %0d/%0d",
                                n_checked, want.smoothed, got.smoothed, want.next_ang,
                                got.next_ang, want.rate, got.rate);
                        end
                    end
                end
                rx_wait = ($urandom_range(0, 99) < rx_calm_pct) ? 0 : $urandom_range(0, 10);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_outputs.size());
            $display("tb: failure");
            $finish;
        end
    end

    // reset, directed steps, then randomized limit settings with random steps
    initial begin : stimulus
        longint alo, ahi, rlo, rhi, atau, stau;
        longint walk_des, walk_meas, des, meas, step;
        bit calm;
        logic mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: clamping of extreme angles, zero and largest step
        queue_cmd(MODE_RESET, 32767, 32767, 1048575, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -32768, -32768, 0, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 32767, 0, 1048575, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 0, 2048, 1000, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 1500, -1500, 1, 0, 0, 0);
        queue_cmd(MODE_RESET, 0, -32768, 0, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -1, 1, 20000, 0, 0, 0);
        wait_drained();

        // widest limits, fastest actuator, slowest smoothing
        program_limits(-32768, 32767, -524288, 524287, 1, 16777215);
        queue_cmd(MODE_UPDATE, 32767, -32768, 1048575, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -32768, 32767, 1048575, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 32767, -32768, 1, 0, 0, 0);
        queue_cmd(MODE_RESET, -32768, 32767, 0, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -32768, 32767, 0, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 0, 0, 50000, 0, 0, 0);
        wait_drained();

        // inverted angle and rate limits, zero actuator constant; the kept target
        // is still far outside the new limits here
        program_limits(1000, -1000, 5000, 100, 0, 50000);
        queue_cmd(MODE_UPDATE, 32767, -32768, 100, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -32768, 32767, 1048575, 0, 0, 0);
        queue_cmd(MODE_RESET, 0, 0, 5, 0, 0, 0);
        queue_cmd(MODE_UPDATE, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // zero rate span, slowest actuator, lightest smoothing
        program_limits(-4096, 4096, 0, 0, 16777215, 1);
        queue_cmd(MODE_UPDATE, 4000, -4000, 1048575, 0, 0, 0);
        queue_cmd(MODE_UPDATE, -32768, 32767, 3, 0, 0, 0);
        wait_drained();

        walk_des = 0;
        walk_meas = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       alo = -32768;
                1:       alo = rand_between(-32768, 32767);
                default: alo = rand_between(-8192, -256);
            endcase
            case ($urandom_range(0, 5))
                0:       ahi = 32767;
                1:       ahi = rand_between(-32768, 32767);
                default: ahi = rand_between(256, 8192);
            endcase
            case ($urandom_range(0, 5))
                0:       rlo = -524288;
                1:       rlo = 0;
                2:       rlo = rand_between(-524288, 524287);
                default: rlo = rand_between(-60000, -100);
            endcase
            case ($urandom_range(0, 5))
                0:       rhi = 524287;
                1:       rhi = 0;
                2:       rhi = rand_between(0, 524287);
                default: rhi = rand_between(100, 60000);
            endcase
            case ($urandom_range(0, 6))
                0:       atau = 1;
                1:       atau = 16777215;
                2:       atau = 0;
                3:       atau = rand_between(0, 16777215);
                default: atau = rand_between(1000, 400000);
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2: stau = 0;
                3:       stau = 16777215;
                4:       stau = rand_between(0, 16777215);
                default: stau = rand_between(1, 200000);
            endcase
            program_limits(alo, ahi, rlo, rhi, atau, stau);

            // some phases run with no idling on either side
            calm = (p % 4 == 1);
            case (p % 3)
                0:       rx_calm_pct = 100;
                1:       rx_calm_pct = 0;
                default: rx_calm_pct = 50;
            endcase
            if (calm) rx_calm_pct = 100;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly a slowly moving command and actuator, some wild values
                walk_des  = clip(walk_des + rand_between(-600, 600), -32768, 32767);
                walk_meas = clip(walk_meas + rand_between(-600, 600), -32768, 32767);
                des  = ($urandom_range(0, 9) < 3) ? longint'($signed(16'($urandom))) : walk_des;
                meas = ($urandom_range(0, 9) < 2) ? longint'($signed(16'($urandom))) : walk_meas;
                mode = ($urandom_range(0, 99) < 8) ? MODE_RESET : MODE_UPDATE;
                case ($urandom_range(0, 4))
                    0:       step = rand_between(1, 2000);
                    1, 2:    step = rand_between(1, 20000);
                    3:       step = longint'($urandom_range(0, 20'hFFFFF));
                    default: step = rand_between(500000, 1048575);
                endcase
                queue_cmd(mode, des, meas, step, calm ? 0 : int'($urandom_range(0, 10)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
            end
            wait_drained();
        end

        repeat (200) @(posedge i_clk);
        $display("covered %0d control steps (%0d target resets) over %0d limit settings",
                 n_accepted, n_resets, n_settings + 1);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 n_writes, n_checked, n_errors);
        if (n_errors == 0 && expected_outputs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
